### rtl/bba_pkg.sv
// Shared types and codes of the bitmap bit allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int IndexW    = 12;
  localparam int CountW    = 13;
  localparam int IndexSpan = 4096;

  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_TEST  = 2'd2;
  localparam logic [1:0] ACT_ALLOC = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [IndexW-1:0] bit_index;
  } bba_req_t;

  typedef struct packed {
    logic [IndexW-1:0] result_index;
    logic              old_value;
    logic [CountW-1:0] marked_count;
    logic [1:0]        status;
  } bba_rsp_t;

endpackage

`default_nettype wire

### rtl/bitmap_bit_allocator_top.sv
// Bitmap bit allocator: word memory, search pointer and request sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Bitmap of WORD_COUNT words of WORD_BITS bits held in one synchronous RAM.
// After reset the block runs a clearing pass over all WORD_COUNT words with
// in_ready_o low. Set, clear and test each go through accept, word index,
// RAM read, then modify/write-back with the result loaded into the output
// register, or held in a wait state while it is busy; an index outside the
// usable range is answered after the read step. Allocate reads one more word
// for every completely set word it steps over, and answers full after the
// read step when the pointer is already past the last used word: a pointer
// marks the lowest word that may still hold a clear bit and only moves back
// when a clear hits a lower word. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted.
module bitmap_bit_allocator_top #(
  parameter int WORD_COUNT = 128,
  parameter int WORD_BITS  = 32
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire bba_pkg::bba_req_t in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output bba_pkg::bba_rsp_t out_data_o
);

  import bba_pkg::*;

  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int HW         = $clog2(WORD_COUNT + 1);
  localparam int PW         = $clog2(WORD_BITS);
  localparam int AllBits    = WORD_COUNT * WORD_BITS;
  localparam int Usable     = (AllBits < IndexSpan) ? AllBits : IndexSpan;
  localparam int UsedWords  = (Usable + WORD_BITS - 1) / WORD_BITS;
  // reciprocal for the word index; exact for every 12-bit index
  localparam int Shift      = 24;
  localparam int Recip      = ((1 << Shift) + WORD_BITS - 1) / WORD_BITS;
  localparam int ProdW      = IndexW + Shift;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        clr_addr_q, clr_addr_d;
  logic [HW-1:0]        hint_q, hint_d;
  logic [CountW-1:0]    marked_q, marked_d;
  logic                 out_valid_q, out_valid_d;
  bba_req_t             req_q, req_d;
  logic [IndexW-1:0]    word_q, word_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [CountW-1:0]    base_q, base_d;
  bba_rsp_t             res_q, res_d;
  bba_rsp_t             out_q, out_d;

  logic [WORD_BITS-1:0] store_mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data_q;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [ProdW-1:0]     prod;
  logic [PW-1:0]        first_zero;
  logic [WORD_BITS-1:0] zero_mask;
  logic [WORD_BITS-1:0] pos_mask;
  logic [CountW-1:0]    grant;
  logic                 is_alloc;
  logic                 old_bit;
  logic                 out_free;
  logic                 emit;
  bba_rsp_t             rsp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign prod     = ProdW'(req_q.bit_index) * ProdW'(Recip);
  assign is_alloc = (req_q.action == ACT_ALLOC);
  assign pos_mask = WORD_BITS'(1) << pos_q;
  assign old_bit  = rd_data_q[pos_q];
  assign grant    = base_q + CountW'(first_zero);
  assign out_free = !out_valid_q || out_ready_i;

  // lowest clear bit of the word just read
  always_comb begin
    first_zero = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_data_q[i]) begin
        first_zero = PW'(i);
      end
    end
  end

  assign zero_mask = WORD_BITS'(1) << first_zero;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    hint_d      = hint_q;
    marked_d    = marked_q;
    out_valid_d = out_valid_q;
    req_d       = req_q;
    word_d      = word_q;
    pos_d       = pos_q;
    base_d      = base_q;
    res_d       = res_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = word_q[AW-1:0];
    mem_wdata   = '0;
    rd_addr     = word_q[AW-1:0];
    emit        = 1'b0;
    rsp         = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(WORD_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        word_d  = prod[Shift +: IndexW];
        state_d = S_READ;
      end
      S_READ: begin
        pos_d  = PW'(req_q.bit_index - IndexW'(word_q * WORD_BITS));
        base_d = CountW'(hint_q * WORD_BITS);
        if (is_alloc) begin
          rd_addr = hint_q[AW-1:0];
        end
        if (is_alloc && (hint_q >= HW'(UsedWords))) begin
          emit       = 1'b1;
          rsp.status = ST_FULL;
        end else if (!is_alloc && ({1'b0, req_q.bit_index} >= CountW'(Usable))) begin
          emit             = 1'b1;
          rsp.result_index = req_q.bit_index;
          rsp.status       = ST_RANGE;
        end else begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (is_alloc) begin
          mem_waddr = hint_q[AW-1:0];
          mem_wdata = rd_data_q | zero_mask;
          if (&rd_data_q) begin
            hint_d  = hint_q + HW'(1);
            state_d = S_READ;
          end else if (grant >= CountW'(Usable)) begin
            emit       = 1'b1;
            rsp.status = ST_FULL;
          end else begin
            mem_we           = 1'b1;
            marked_d         = marked_q + CountW'(1);
            emit             = 1'b1;
            rsp.result_index = grant[IndexW-1:0];
            rsp.status       = ST_OK;
            if (&mem_wdata) begin
              hint_d = hint_q + HW'(1);
            end
          end
        end else begin
          emit             = 1'b1;
          rsp.result_index = req_q.bit_index;
          rsp.old_value    = old_bit;
          rsp.status       = ST_OK;
          if (req_q.action == ACT_SET && !old_bit) begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_q | pos_mask;
            marked_d  = marked_q + CountW'(1);
          end else if (req_q.action == ACT_CLEAR && old_bit) begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_q & ~pos_mask;
            marked_d  = marked_q - CountW'(1);
            if ({1'b0, word_q} < (IndexW + 1)'(hint_q)) begin
              hint_d = HW'(word_q);
            end
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit) begin
      rsp.marked_count = marked_d;
      if (out_free) begin
        out_d       = rsp;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        res_d   = rsp;
        state_d = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      hint_q      <= '0;
      marked_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      hint_q      <= hint_d;
      marked_q    <= marked_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    word_q <= word_d;
    pos_q  <= pos_d;
    base_q <= base_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= store_mem[rd_addr];
  end

`ifndef SYNTHESIS
  // the count can never exceed the number of usable bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    marked_q <= CountW'(Usable))
    else $error("marked count beyond usable bits");

  // search pointer stays at most one past the last used word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= HW'(UsedWords))
    else $error("search pointer out of range");

  // a full allocate reports index 0 and old value 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_FULL) |->
      (out_data_o.result_index == '0 && !out_data_o.old_value))
    else $error("full status with nonzero payload");

  // no memory write outside the clearing pass and the modify step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_MOD))
    else $error("unexpected memory write");
`endif

endmodule

`default_nettype wire
